/* sv/psue_pkg.sv */
package psue_pkg;

    localparam int PARTICLES = 32;
    localparam int DIMS      = 16;
    localparam int P_W       = 5;
    localparam int D_W       = 4;
    localparam int A_W       = P_W + D_W;
    localparam int ND_W      = 5;
    localparam int S_TDATA_W = 208;
    localparam int M_TDATA_W = 136;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    localparam logic [2:0] REG_INERTIA = 3'd0;
    localparam logic [2:0] REG_COGN    = 3'd1;
    localparam logic [2:0] REG_SOCIAL  = 3'd2;
    localparam logic [2:0] REG_RATIO   = 3'd3;
    localparam logic [2:0] REG_ACTIVE  = 3'd4;

    typedef struct packed {
        logic [15:0]     inertia;
        logic [15:0]     cogn;
        logic [15:0]     social;
        logic [15:0]     ratio;
        logic [ND_W-1:0] active;
    } cfg_t;

    typedef struct packed {
        cmd_t               cmd;
        logic               ok;
        logic [P_W-1:0]     particle;
        logic [D_W-1:0]     dim;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic [15:0]        r1;
        logic [15:0]        r2;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [31:0]        fit;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_t;

    typedef struct packed {
        logic [1:0] count;
    } fstat_t;

    function automatic logic [ND_W-1:0] dims_in_use(input logic [ND_W-1:0] active);
        logic [ND_W-1:0] lim;
        lim = ND_W'(DIMS);
        return (active > lim) ? lim : active;
    endfunction

endpackage

/* sv/particle_swarm_update_engine.sv */
// Particle swarm update engine. Commands arrive on the s_ channel (kind in s_tuser:
// load, report fitness, update dimension, read swarm best) and each yields exactly one
// result transaction on the m_ channel. A two-entry queue decouples acceptance from
// execution, and a result register lets the next command be taken while a result waits.
// One command executes at a time: load, read and a report with no improvement finish in
// the idle state that takes them; an update steps through a read state, four passes of a
// single shared 34x17 multiplier after a registered memory read, a clip and a position
// state; a report that improves a best walks the dimensions in use, one coordinate copied per
// cycle through the position memory read port. Position, velocity and personal best live
// in memories of particles x dimensions entries with no reset; update or report of a
// never loaded entry gives undefined values. The user must write registers through cfg_*
// only while idle; the block itself does not enforce this.
module particle_swarm_update_engine import psue_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_addr,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // particle, dimension_index, position_in, velocity_in, rand_cognitive,
    // rand_social, lower_bound, upper_bound, fitness, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // new_position, new_velocity, particle_improved, swarm_improved,
    // swarm_best_fitness, swarm_best_coord, zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    cfg_t   cfg_reg;
    queue_t q;
    logic   q_pop;
    fstat_t fstat;
    logic [2:0] inflight_reg, inflight_next;

    // configuration registers: write only, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inertia <= 16'd2867;
            cfg_reg.cogn    <= 16'd6144;
            cfg_reg.social  <= 16'd6144;
            cfg_reg.ratio   <= 16'd13107;
            cfg_reg.active  <= ND_W'(16);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_INERTIA: cfg_reg.inertia <= cfg_wr_data;
                REG_COGN:    cfg_reg.cogn    <= cfg_wr_data;
                REG_SOCIAL:  cfg_reg.social  <= cfg_wr_data;
                REG_RATIO:   cfg_reg.ratio   <= cfg_wr_data;
                REG_ACTIVE:  cfg_reg.active  <= cfg_wr_data[ND_W-1:0];
                default: ;
            endcase
        end
    end

    psue_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .q        (q),
        .q_pop    (q_pop),
        .fstat    (fstat)
    );

    psue_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q        (q),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // count commands accepted but not yet delivered
    assign inflight_next = inflight_reg + 3'(s_tvalid && s_tready) - 3'(m_tvalid && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // queue, execution and result register hold at most four commands
    assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 3'd4 && fstat.count <= 2'd2)
        else $error("more commands in flight than storage holds");

    // no result without an accepted command
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != 3'd0)
        else $error("result transaction without a command");

    // swarm best is the least personal best, so a swarm gain is also a personal gain
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[65] |-> m_tdata[64])
        else $error("swarm improved without particle improvement");

endmodule

/* sv/psue_front.sv */
module psue_front import psue_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  cfg_t                 cfg,
    output queue_t               q,
    input  logic                 q_pop,
    output fstat_t               fstat
);

    item_t      ent_reg [2];
    logic [1:0] count_reg, count_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    item_t      in_item;
    logic       push;
    logic       p_ok;
    logic [ND_W-1:0] nd;

    always_comb begin
        nd = dims_in_use(cfg.active);
        in_item.cmd      = cmd_t'(s_tuser);
        in_item.particle = s_tdata[4:0];
        in_item.dim      = s_tdata[8:5];
        in_item.pos      = s_tdata[40:9];
        in_item.vel      = s_tdata[72:41];
        in_item.r1       = s_tdata[88:73];
        in_item.r2       = s_tdata[104:89];
        in_item.lo       = s_tdata[136:105];
        in_item.hi       = s_tdata[168:137];
        in_item.fit      = s_tdata[200:169];
        p_ok = ({1'b0, in_item.particle} < (P_W+1)'(PARTICLES));
        case (in_item.cmd)
            CMD_LOAD, CMD_UPDATE: in_item.ok = p_ok && ({1'b0, in_item.dim} < nd);
            CMD_REPORT:           in_item.ok = p_ok;
            CMD_READ:             in_item.ok = ({1'b0, in_item.dim} < (D_W+1)'(DIMS));
            default:              in_item.ok = 1'b0;
        endcase
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;

    always_comb begin
        count_next  = count_reg + 2'(push) - 2'(q_pop);
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        wr_ptr_next = wr_ptr_reg ^ push;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign q.valid      = (count_reg != 2'd0);
    assign q.item       = ent_reg[rd_ptr_reg];
    assign fstat.count  = count_reg;

endmodule

/* sv/psue_back.sv */
module psue_back import psue_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  queue_t               q,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_URD  = 9'b000000010,
        ST_M1   = 9'b000000100,
        ST_M2   = 9'b000001000,
        ST_M3   = 9'b000010000,
        ST_M4   = 9'b000100000,
        ST_CLIP = 9'b001000000,
        ST_POS  = 9'b010000000,
        ST_COPY = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    item_t  wk_reg, wk_next;
    logic [15:0]        k1_reg, k1_next, k2_reg, k2_next;
    logic signed [32:0] range_reg, range_next;
    logic signed [51:0] acc_reg, acc_next;
    logic signed [35:0] mv_reg, mv_next;
    logic signed [31:0] vel_reg, vel_next;
    logic pimp_reg, pimp_next, simp_reg, simp_next;
    logic [ND_W-1:0] cnt_reg, cnt_next;
    logic cpv_reg, cpv_next;
    logic [D_W-1:0] cpi_reg, cpi_next;
    logic [31:0] pbf_reg [PARTICLES];
    logic [31:0] pbf_next [PARTICLES];
    logic [31:0] sbs_reg, sbs_next;
    logic signed [31:0] sbv_reg [DIMS];
    logic signed [31:0] sbv_next [DIMS];
    logic                 mv_out_reg, mv_out_next;
    logic [M_TDATA_W-1:0] md_reg, md_next;

    logic signed [31:0] pos_mem [PARTICLES*DIMS];
    logic signed [31:0] vel_mem [PARTICLES*DIMS];
    logic signed [31:0] pb_mem  [PARTICLES*DIMS];
    logic signed [31:0] pos_q, vel_q, pb_q;
    logic [A_W-1:0] rd_addr, wr_addr;
    logic we_pos, we_vel, we_pb;
    logic signed [31:0] wd_pos, wd_vel, wd_pb;

    logic signed [33:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [50:0] prod;
    logic signed [32:0] d1, d2;
    logic signed [51:0] mv_sum;
    logic signed [52:0] v_sum;
    logic signed [41:0] v_rnd, v_clip, mv_ext;
    logic signed [32:0] xs;
    logic signed [31:0] xn;
    logic [31:0] kp1, kp2;
    logic [ND_W-1:0] nd;
    logic fin;
    logic signed [31:0] npos, nvel, coord;

    assign nd = dims_in_use(cfg.active);

    always_comb begin
        rd_addr = (state_reg == ST_COPY) ? {wk_reg.particle, cnt_reg[D_W-1:0]}
                                         : {wk_reg.particle, wk_reg.dim};
        d1 = 33'(pb_q) - 33'(pos_q);
        d2 = 33'(sbv_reg[wk_reg.dim]) - 33'(pos_q);
        case (state_reg)
            ST_M1: begin
                mul_a = 34'(vel_q);
                mul_b = $signed({1'b0, cfg.inertia});
            end
            ST_M2: begin
                mul_a = 34'(d1);
                mul_b = $signed({1'b0, k1_reg});
            end
            ST_M3: begin
                mul_a = 34'(d2);
                mul_b = $signed({1'b0, k2_reg});
            end
            ST_M4: begin
                mul_a = 34'(range_reg);
                mul_b = $signed({1'b0, cfg.ratio});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod   = mul_a * mul_b;
        mv_sum = 52'(prod) + 52'sd32768;
        v_sum  = 53'(acc_reg) + 53'sd2048;
        v_rnd  = 42'($signed(v_sum[52:12]));
        mv_ext = 42'(mv_reg);
        v_clip = v_rnd;
        if (v_clip > mv_ext) v_clip = mv_ext;
        if (v_clip < -mv_ext) v_clip = -mv_ext;
        xs = 33'(pos_q) + 33'(vel_reg);
        if (xs < 33'(wk_reg.lo)) xs = 33'(wk_reg.lo);
        if (xs > 33'(wk_reg.hi)) xs = 33'(wk_reg.hi);
        xn  = xs[31:0];
        kp1 = cfg.cogn * wk_reg.r1;
        kp2 = cfg.social * wk_reg.r2;
    end

    always_comb begin
        state_next = state_reg;
        wk_next    = wk_reg;
        k1_next    = k1_reg;
        k2_next    = k2_reg;
        range_next = range_reg;
        acc_next   = acc_reg;
        mv_next    = mv_reg;
        vel_next   = vel_reg;
        pimp_next  = pimp_reg;
        simp_next  = simp_reg;
        cnt_next   = cnt_reg;
        cpv_next   = cpv_reg;
        cpi_next   = cpi_reg;
        pbf_next   = pbf_reg;
        sbs_next   = sbs_reg;
        sbv_next   = sbv_reg;
        q_pop  = 1'b0;
        fin    = 1'b0;
        npos   = '0;
        nvel   = '0;
        coord  = '0;
        we_pos = 1'b0;
        we_vel = 1'b0;
        we_pb  = 1'b0;
        wr_addr = {wk_reg.particle, wk_reg.dim};
        wd_pos = xn;
        wd_vel = vel_reg;
        wd_pb  = pos_q;
        case (state_reg)
            ST_IDLE: begin
                if (q.valid && (!mv_out_reg || m_tready)) begin
                    q_pop     = 1'b1;
                    wk_next   = q.item;
                    pimp_next = 1'b0;
                    simp_next = 1'b0;
                    case (q.item.cmd)
                        CMD_LOAD: begin
                            fin = 1'b1;
                            if (q.item.ok) begin
                                wr_addr = {q.item.particle, q.item.dim};
                                we_pos = 1'b1;
                                we_vel = 1'b1;
                                we_pb  = 1'b1;
                                wd_pos = q.item.pos;
                                wd_vel = q.item.vel;
                                wd_pb  = q.item.pos;
                                npos   = q.item.pos;
                                nvel   = q.item.vel;
                            end
                        end
                        CMD_UPDATE: begin
                            if (q.item.ok) state_next = ST_URD;
                            else fin = 1'b1;
                        end
                        CMD_REPORT: begin
                            if (q.item.ok) begin
                                // strict improvement only; the swarm best is the
                                // minimum of all personal bests
                                if (q.item.fit < pbf_reg[q.item.particle]) begin
                                    pimp_next = 1'b1;
                                    pbf_next[q.item.particle] = q.item.fit;
                                end
                                if (q.item.fit < sbs_reg) begin
                                    simp_next = 1'b1;
                                    sbs_next  = q.item.fit;
                                end
                            end
                            if (pimp_next || simp_next) begin
                                state_next = ST_COPY;
                                cnt_next   = '0;
                                cpv_next   = 1'b0;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        CMD_READ: begin
                            fin = 1'b1;
                            if (q.item.ok) coord = sbv_reg[q.item.dim];
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            ST_URD: begin
                k1_next    = kp1[31:16];
                k2_next    = kp2[31:16];
                range_next = 33'(wk_reg.hi) - 33'(wk_reg.lo);
                state_next = ST_M1;
            end
            ST_M1: begin
                acc_next   = 52'(prod);
                state_next = ST_M2;
            end
            ST_M2: begin
                acc_next   = acc_reg + 52'(prod);
                state_next = ST_M3;
            end
            ST_M3: begin
                acc_next   = acc_reg + 52'(prod);
                state_next = ST_M4;
            end
            ST_M4: begin
                mv_next    = mv_sum[51:16];
                state_next = ST_CLIP;
            end
            ST_CLIP: begin
                if (v_clip > 42'sd2147483647) vel_next = 32'sh7FFFFFFF;
                else if (v_clip < -42'sd2147483648) vel_next = 32'sh80000000;
                else vel_next = v_clip[31:0];
                state_next = ST_POS;
            end
            ST_POS: begin
                we_pos = 1'b1;
                we_vel = 1'b1;
                npos   = xn;
                nvel   = vel_reg;
                fin    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_COPY: begin
                if (cpv_reg) begin
                    wr_addr = {wk_reg.particle, cpi_reg};
                    we_pb   = pimp_reg;
                    if (simp_reg) sbv_next[cpi_reg] = pos_q;
                end
                if (cnt_reg < nd) begin
                    cnt_next = cnt_reg + 1'b1;
                    cpv_next = 1'b1;
                    cpi_next = cnt_reg[D_W-1:0];
                end else begin
                    cpv_next = 1'b0;
                    if (!cpv_reg) begin
                        fin = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        mv_out_next = mv_out_reg && !m_tready;
        md_next     = md_reg;
        if (fin) begin
            mv_out_next = 1'b1;
            md_next = {6'b0, coord, sbs_next, simp_next, pimp_next, nvel, npos};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mv_out_reg <= 1'b0;
            sbs_reg    <= '1;
            for (int i = 0; i < PARTICLES; i++) pbf_reg[i] <= '1;
            for (int i = 0; i < DIMS; i++) sbv_reg[i] <= '0;
        end else begin
            state_reg  <= state_next;
            mv_out_reg <= mv_out_next;
            sbs_reg    <= sbs_next;
            pbf_reg    <= pbf_next;
            sbv_reg    <= sbv_next;
        end
    end

    always_ff @(posedge aclk) begin
        wk_reg    <= wk_next;
        k1_reg    <= k1_next;
        k2_reg    <= k2_next;
        range_reg <= range_next;
        acc_reg   <= acc_next;
        mv_reg    <= mv_next;
        vel_reg   <= vel_next;
        pimp_reg  <= pimp_next;
        simp_reg  <= simp_next;
        cnt_reg   <= cnt_next;
        cpv_reg   <= cpv_next;
        cpi_reg   <= cpi_next;
        md_reg    <= md_next;
    end

    always_ff @(posedge aclk) begin
        if (we_pos) pos_mem[wr_addr] <= wd_pos;
        if (we_vel) vel_mem[wr_addr] <= wd_vel;
        if (we_pb)  pb_mem[wr_addr]  <= wd_pb;
        pos_q <= pos_mem[rd_addr];
        vel_q <= vel_mem[rd_addr];
        pb_q  <= pb_mem[rd_addr];
    end

    assign m_tvalid = mv_out_reg;
    assign m_tdata  = md_reg;

endmodule
